// ----- rtl/core/mfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_pkg: motor feedback frame decoder package
// Field widths, register reset value and scaling constants shared by the
// decoder modules.
// ----------------------------------------------------------------------------
package mfd_pkg;

  // input word fields
  localparam int CNT_W  = 13;
  localparam int SPD_W  = 16;
  localparam int CUR_W  = 16;
  localparam int TEMP_W = 8;

  // scale register, Q8.24 degrees per count over gear ratio
  localparam int          DPC_W     = 32;
  localparam logic [31:0] DPC_RESET = 32'd737362;

  // result word fields
  localparam int ANG_W     = 48;
  localparam int DELTA_W   = 32;
  localparam int SPD_OUT_W = 19;
  localparam int CUR_OUT_W = 20;
  localparam int RUN_W     = 32;

  // packed stream widths, rounded up to whole bytes
  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 160;

  // rpm to deg/s, and current word to Q.16 amps (3/16384 * 65536)
  localparam int SPD_SCALE = 6;
  localparam int CUR_SCALE = 12;

  // product is Q.24 * counts; drop 8 bits with round half away from zero
  localparam int ROUND_SHIFT = 8;
  localparam int ROUND_BIAS  = 128;

endpackage

// ----- rtl/core/mfd_unwrap.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_unwrap: encoder delta unwrap
// Clamps the encoder count to the turn length, takes the change from the
// previous count and folds it into half a turn. Result as sign and magnitude.
// ----------------------------------------------------------------------------
module mfd_unwrap #(
  parameter int ENCODER_MAX = 8191
) (
  input  logic [mfd_pkg::CNT_W-1:0]          count_i,
  input  logic [mfd_pkg::CNT_W-1:0]          prev_i,
  output logic [mfd_pkg::CNT_W-1:0]          count_clamped_o,
  output logic [$clog2(ENCODER_MAX+1)-1:0]   mag_o,
  output logic                               neg_o
);

  localparam int MAG_W = $clog2(ENCODER_MAX + 1);
  localparam int CMP_W = (MAG_W > mfd_pkg::CNT_W) ? MAG_W : mfd_pkg::CNT_W;
  localparam int DW    = CMP_W + 2;

  logic [CMP_W-1:0]     clamped;
  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] twice;
  logic signed [DW-1:0] emax_s;
  logic signed [DW-1:0] adj;
  logic signed [DW-1:0] abs_v;

  always_comb begin
    if (CMP_W'(count_i) > CMP_W'(ENCODER_MAX)) begin
      clamped = CMP_W'(ENCODER_MAX);
    end else begin
      clamped = CMP_W'(count_i);
    end
    // prev_i was clamped when stored
    diff   = $signed(DW'(clamped)) - $signed(DW'(prev_i));
    twice  = diff <<< 1;
    emax_s = $signed(DW'(ENCODER_MAX));
    if (twice > emax_s) begin
      adj = diff - emax_s;
    end else if (twice < -emax_s) begin
      adj = diff + emax_s;
    end else begin
      adj = diff;
    end
    neg_o = adj[DW-1];
    abs_v = neg_o ? -adj : adj;
  end

  assign mag_o           = abs_v[MAG_W-1:0];
  assign count_clamped_o = clamped[mfd_pkg::CNT_W-1:0];

endmodule

// ----- rtl/core/motor_feedback_frame_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_feedback_frame_decoder: feedback frame decode with multi-turn angle
// Converts speed and current words, unwraps the encoder delta, scales it to
// output degrees and keeps a saturating multi-turn angle and run counter.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                 Payload
// s_axis    in   tvalid/tready             count, speed, current, temperature
// m_axis    out  tvalid/tready             angle, delta, speed, current,
//                                          temperature, direction ticks
// cfg       in   cfg_we_i (always taken)   degrees_per_count
//
// Three register stages: input (unwrapped delta), scale (multiply and round),
// result (saturate, accumulate). One word per cycle sustained while m_axis does
// not stall. The 48-bit accumulator add is the feedback loop that sets the rate;
// the multiply sits in the stage before it.
// Reset clears stage valids, previous count, angle and run counter, and loads
// the default scale. A stall at m_axis backs up stage by stage; empty stages
// still take words, so up to three words can be held.
//
module motor_feedback_frame_decoder #(
  parameter int ENCODER_MAX = 8191
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write
  input  logic                            cfg_we_i,
  input  logic [mfd_pkg::DPC_W-1:0]       cfg_wdata_i,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [12:0] encoder_count, [28:13] speed_rpm, [44:29] current_word,
  // [52:45] temperature, [55:53] zero
  input  logic [mfd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [47:0] angle_deg_q16, [79:48] delta_deg_q16, [98:80] speed_dps,
  // [118:99] current_amps_q16, [126:119] temperature_out,
  // [158:127] direction_ticks, [159] zero
  output logic [mfd_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  localparam int MAG_W = $clog2(ENCODER_MAX + 1);
  localparam int P_W   = MAG_W + mfd_pkg::DPC_W;
  localparam int R_W   = P_W + 1 - mfd_pkg::ROUND_SHIFT;

  localparam int ANG_W   = mfd_pkg::ANG_W;
  localparam int DELTA_W = mfd_pkg::DELTA_W;
  localparam int RUN_W   = mfd_pkg::RUN_W;

  // field unpack
  logic [mfd_pkg::CNT_W-1:0]         in_count;
  logic signed [mfd_pkg::SPD_W-1:0]  in_speed;
  logic signed [mfd_pkg::CUR_W-1:0]  in_cur;
  logic [mfd_pkg::TEMP_W-1:0]        in_temp;

  assign in_count = s_axis_tdata[12:0];
  assign in_speed = $signed(s_axis_tdata[28:13]);
  assign in_cur   = $signed(s_axis_tdata[44:29]);
  assign in_temp  = s_axis_tdata[52:45];

  // stage control
  logic v1_q, v2_q, v3_q;
  logic mv1, mv2, ld3, acc_in;

  assign ld3           = v2_q && (!v3_q || m_axis_tready);
  assign mv2           = !v2_q || !v3_q || m_axis_tready;
  assign mv1           = !v1_q || mv2;
  assign s_axis_tready = mv1;
  assign acc_in        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = v3_q;

  // scale register
  logic [mfd_pkg::DPC_W-1:0] dpc_q;

  // unwrap against previous count
  logic [mfd_pkg::CNT_W-1:0] prev_q;
  logic [mfd_pkg::CNT_W-1:0] count_clamped;
  logic [MAG_W-1:0]          un_mag;
  logic                      un_neg;

  mfd_unwrap #(
    .ENCODER_MAX (ENCODER_MAX)
  ) u_unwrap (
    .count_i         (in_count),
    .prev_i          (prev_q),
    .count_clamped_o (count_clamped),
    .mag_o           (un_mag),
    .neg_o           (un_neg)
  );

  // stage 1 payload
  logic [MAG_W-1:0]                  mag1_q;
  logic                              neg1_q;
  logic signed [mfd_pkg::SPD_W-1:0]  spd1_q;
  logic signed [mfd_pkg::CUR_W-1:0]  cur1_q;
  logic [mfd_pkg::TEMP_W-1:0]        temp1_q;

  // stage 2 payload
  logic [R_W-1:0]                    r2_q;
  logic                              neg2_q;
  logic signed [mfd_pkg::SPD_W-1:0]  spd2_q;
  logic signed [mfd_pkg::CUR_W-1:0]  cur2_q;
  logic [mfd_pkg::TEMP_W-1:0]        temp2_q;

  // result payload; angle and run state double as result fields
  logic signed [DELTA_W-1:0]            delta3_q;
  logic signed [mfd_pkg::SPD_OUT_W-1:0] spd3_q;
  logic signed [mfd_pkg::CUR_OUT_W-1:0] cur3_q;
  logic [mfd_pkg::TEMP_W-1:0]           temp3_q;
  logic signed [ANG_W-1:0]              acc_q, acc_d;
  logic signed [RUN_W-1:0]              run_q, run_d;

  // stage 2 math: magnitude times scale plus rounding bias
  logic [P_W-1:0] prod;
  logic [P_W:0]   rnd_sum;
  logic [R_W-1:0] r2_d;

  assign prod    = P_W'(mag1_q) * P_W'(dpc_q);
  assign rnd_sum = (P_W+1)'(prod) + (P_W+1)'(mfd_pkg::ROUND_BIAS);
  assign r2_d    = rnd_sum[P_W:mfd_pkg::ROUND_SHIFT];

  // stage 3 math: saturate delta, accumulate, run counter
  localparam logic signed [DELTA_W-1:0] DELTA_MAX = {1'b0, {(DELTA_W-1){1'b1}}};
  localparam logic signed [DELTA_W-1:0] DELTA_MIN = {1'b1, {(DELTA_W-1){1'b0}}};
  localparam logic signed [ANG_W-1:0]   ANG_MAX   = {1'b0, {(ANG_W-1){1'b1}}};
  localparam logic signed [ANG_W-1:0]   ANG_MIN   = {1'b1, {(ANG_W-1){1'b0}}};
  localparam logic signed [RUN_W-1:0]   RUN_MAX   = {1'b0, {(RUN_W-1){1'b1}}};
  localparam logic signed [RUN_W-1:0]   RUN_MIN   = {1'b1, {(RUN_W-1){1'b0}}};
  localparam logic [R_W-1:0]            R_POS_LIM = R_W'(DELTA_MAX);
  localparam logic [R_W-1:0]            R_NEG_LIM = R_W'(DELTA_MAX) + R_W'(1);

  logic signed [DELTA_W-1:0] delta_d;
  logic [ANG_W:0]            acc_sum;

  always_comb begin
    if (neg2_q) begin
      if (r2_q > R_NEG_LIM) begin
        delta_d = DELTA_MIN;
      end else begin
        delta_d = $signed(DELTA_W'(-r2_q));
      end
    end else begin
      if (r2_q > R_POS_LIM) begin
        delta_d = DELTA_MAX;
      end else begin
        delta_d = $signed(DELTA_W'(r2_q));
      end
    end

    acc_sum = {acc_q[ANG_W-1], acc_q}
            + {{(ANG_W+1-DELTA_W){delta_d[DELTA_W-1]}}, delta_d};
    if (acc_sum[ANG_W] != acc_sum[ANG_W-1]) begin
      acc_d = acc_sum[ANG_W] ? ANG_MIN : ANG_MAX;
    end else begin
      acc_d = $signed(acc_sum[ANG_W-1:0]);
    end

    // run resets on reversal, clears at standstill, saturates
    if (spd2_q < 0) begin
      if (run_q > 0) begin
        run_d = -RUN_W'(1);
      end else if (run_q != RUN_MIN) begin
        run_d = run_q - RUN_W'(1);
      end else begin
        run_d = run_q;
      end
    end else if (spd2_q > 0) begin
      if (run_q < 0) begin
        run_d = RUN_W'(1);
      end else if (run_q != RUN_MAX) begin
        run_d = run_q + RUN_W'(1);
      end else begin
        run_d = run_q;
      end
    end else begin
      run_d = '0;
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      dpc_q  <= mfd_pkg::DPC_RESET;
      prev_q <= '0;
      acc_q  <= '0;
      run_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        dpc_q <= cfg_wdata_i;
      end
      if (mv1) begin
        v1_q <= acc_in;
      end
      if (mv2) begin
        v2_q <= v1_q;
      end
      if (ld3) begin
        v3_q <= 1'b1;
      end else if (m_axis_tready) begin
        v3_q <= 1'b0;
      end
      if (acc_in) begin
        prev_q <= count_clamped;
      end
      if (ld3) begin
        acc_q <= acc_d;
        run_q <= run_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      mag1_q  <= un_mag;
      neg1_q  <= un_neg;
      spd1_q  <= in_speed;
      cur1_q  <= in_cur;
      temp1_q <= in_temp;
    end
    if (mv2 && v1_q) begin
      r2_q    <= r2_d;
      neg2_q  <= neg1_q;
      spd2_q  <= spd1_q;
      cur2_q  <= cur1_q;
      temp2_q <= temp1_q;
    end
    if (ld3) begin
      delta3_q <= delta_d;
      spd3_q   <= mfd_pkg::SPD_OUT_W'(spd2_q)
                * mfd_pkg::SPD_OUT_W'(mfd_pkg::SPD_SCALE);
      cur3_q   <= mfd_pkg::CUR_OUT_W'(cur2_q)
                * mfd_pkg::CUR_OUT_W'(mfd_pkg::CUR_SCALE);
      temp3_q  <= temp2_q;
    end
  end

  assign m_axis_tdata = {1'b0, run_q, temp3_q, cur3_q, spd3_q, delta3_q, acc_q};

  // checks
  a_mag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (32'(mag1_q) <= 32'(ENCODER_MAX)))
    else $error("unwrapped delta exceeds one turn");

  a_acc_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld3 && (delta_d > 0)) |=> (acc_q >= $past(acc_q)))
    else $error("positive delta lowered the angle");

  a_acc_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld3 && (delta_d < 0)) |=> (acc_q <= $past(acc_q)))
    else $error("negative delta raised the angle");

  a_run_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld3 && (spd2_q == 0)) |=> (run_q == 0))
    else $error("run counter not cleared at standstill");

  a_run_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld3 && (spd2_q > 0)) |=> (run_q > 0))
    else $error("run counter sign disagrees with speed");

endmodule

// ----- tb/tb_motor_feedback_frame_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_feedback_frame_decoder: self-checking bench for the frame decoder
// Streams feedback frames through the decoder and checks every result word
// against a cycle-free predictor of the unwrap, scale, saturating angle and
// direction run counter. It covers several scale settings, delta saturation
// at full scale, random idle on both streams and a long output stall.
// ----------------------------------------------------------------------------
module tb_motor_feedback_frame_decoder;
  import mfd_pkg::*;

  localparam int          ENC_MAX      = 8191;
  localparam longint      ANGLE_MAX    = 64'sd140737488355327;
  localparam longint      ANGLE_MIN    = -ANGLE_MAX - 1;
  localparam int          HOLD_CYCLES  = 120;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          LIMIT_CYCLES = 2000000;
  localparam int          PHASE_FRAMES = 220;

  localparam int S_PAD_W = S_TDATA_W - (CNT_W + SPD_W + CUR_W + TEMP_W);
  localparam int M_PAD_W = M_TDATA_W - (ANG_W + DELTA_W + SPD_OUT_W + CUR_OUT_W + TEMP_W + RUN_W);

  // input word, lowest field in the lowest bits
  typedef struct packed {
    logic [S_PAD_W-1:0] pad;
    logic [TEMP_W-1:0]  temp;
    logic [CUR_W-1:0]   cur;
    logic [SPD_W-1:0]   spd;
    logic [CNT_W-1:0]   cnt;
  } frame_t;

  // result word, lowest field in the lowest bits
  typedef struct packed {
    logic [M_PAD_W-1:0]   pad;
    logic [RUN_W-1:0]     run;
    logic [TEMP_W-1:0]    temp;
    logic [CUR_OUT_W-1:0] cur;
    logic [SPD_OUT_W-1:0] spd;
    logic [DELTA_W-1:0]   delta;
    logic [ANG_W-1:0]     angle;
  } result_t;

  // Tracks decoder state, predicts each result word and checks the output.
  class feedback_checker;
    logic [DPC_W-1:0] scale;
    logic [CNT_W-1:0] last_count;
    longint           angle;
    int               run;
    result_t          pending_results[$];
    int unsigned      errors;
    int unsigned      frames;
    int unsigned      results;

    function new();
      scale      = DPC_RESET;
      last_count = '0;
      angle      = 0;
      run        = 0;
      errors     = 0;
      frames     = 0;
      results    = 0;
    endfunction

    function void set_scale(logic [DPC_W-1:0] v);
      scale = v;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // unwrap, scale with round half away from zero, saturate, accumulate
    function void note_frame(frame_t f);
      logic [CNT_W-1:0]  cnt;
      longint            d;
      longint unsigned   mag;
      longint unsigned   r;
      int                dlt;
      longint            sum;
      int                sp;
      result_t           want;
      frames++;
      cnt = f.cnt;
      if (cnt > ENC_MAX) cnt = ENC_MAX;
      d = longint'(cnt) - longint'(last_count);
      if (2 * d > ENC_MAX) d -= ENC_MAX;
      else if (2 * d < -ENC_MAX) d += ENC_MAX;
      last_count = cnt;

      mag = (d < 0) ? longint'(-d) : longint'(d);
      r   = (mag * 64'(scale) + 64'(ROUND_BIAS)) >> ROUND_SHIFT;
      if (d < 0) begin
        if (r > 64'd2147483648) dlt = 32'h8000_0000;
        else dlt = int'(-longint'(r));
      end else begin
        if (r > 64'd2147483647) dlt = 32'h7fff_ffff;
        else dlt = int'(r);
      end

      sum = angle + longint'(dlt);
      if (sum > ANGLE_MAX) sum = ANGLE_MAX;
      else if (sum < ANGLE_MIN) sum = ANGLE_MIN;
      angle = sum;

      // run counter restarts on a sign change and clears at standstill
      sp = int'($signed(f.spd));
      if (sp < 0) begin
        if (run > 0) run = -1;
        else if (run != 32'sh8000_0000) run = run - 1;
      end else if (sp > 0) begin
        if (run < 0) run = 1;
        else if (run != 32'sh7fff_ffff) run = run + 1;
      end else begin
        run = 0;
      end

      want.pad   = '0;
      want.run   = run;
      want.temp  = f.temp;
      want.cur   = CUR_OUT_W'(int'($signed(f.cur)) * CUR_SCALE);
      want.spd   = SPD_OUT_W'(sp * SPD_SCALE);
      want.delta = dlt;
      want.angle = ANG_W'(angle);
      pending_results.push_back(want);
    endfunction

    function void compare(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: word %0d %s mismatch, expected %0h, actual %0h",
                 $time, results, name, e, a);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      results++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual %0h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      compare("angle_deg_q16", want.angle, got.angle);
      compare("delta_deg_q16", want.delta, got.delta);
      compare("speed_dps", want.spd, got.spd);
      compare("current_amps_q16", want.cur, got.cur);
      compare("temperature_out", want.temp, got.temp);
      compare("direction_ticks", want.run, got.run);
      compare("pad", want.pad, got.pad);
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [DPC_W-1:0]     cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  feedback_checker      checker_h;
  bit                   quiet;      // no idle on either stream while set
  bit                   hold_rx;    // request one long output stall
  logic [CNT_W-1:0]     gen_count;  // last encoder count sent
  int                   gen_dir;    // current turning direction of stimulus
  int unsigned          cycles;
  int unsigned          settings;

  motor_feedback_frame_decoder #(
    .ENCODER_MAX(ENC_MAX)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned sel;
    if (quiet) return 0;
    sel = $urandom_range(0, 19);
    if (sel < 12) return 0;
    if (sel < 17) return $urandom_range(1, 3);
    if (sel < 19) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // speed holds its sign for stretches, with flips and standstills
  function automatic int next_speed();
    int unsigned sel;
    if ($urandom_range(0, 15) == 0) gen_dir = int'($urandom_range(0, 2)) - 1;
    sel = $urandom_range(0, 19);
    if (sel == 0) return int'($signed(SPD_W'($urandom)));
    if (gen_dir == 0) return 0;
    if (sel == 1) return (gen_dir > 0) ? 32767 : -32768;
    return gen_dir * int'($urandom_range(1, 32767));
  endfunction

  // monitors: config writes, accepted input words, accepted result words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) checker_h.set_scale(cfg_wdata_i);
      if (s_axis_tvalid && s_axis_tready) checker_h.note_frame(frame_t'(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) checker_h.check_result(result_t'(m_axis_tdata));
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d words outstanding", $time, checker_h.pending());
      $display("tb_motor_feedback_frame_decoder: done, errors");
      $finish;
    end
  end

  // output side: random stalls, plus one long hold on request
  initial begin
    int unsigned stall;
    stall = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        m_axis_tready <= 1'b0;
      end else if (hold_rx) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_rx = 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  task automatic drive_frame(input logic [CNT_W-1:0] cnt, input int spd, input int cur,
                             input logic [TEMP_W-1:0] temp);
    frame_t      f;
    int unsigned gap;
    f.pad  = '0;
    f.temp = temp;
    f.cur  = CUR_W'(cur);
    f.spd  = SPD_W'(spd);
    f.cnt  = cnt;
    gen_count = cnt;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= f;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop offering and wait until every predicted word has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (checker_h.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_scale(input logic [DPC_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings++;
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned i;
    int unsigned sel;
    int          step;
    logic [CNT_W-1:0] cnt;
    for (i = 0; i < n; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 19);
      if (sel < 4) begin
        cnt = CNT_W'($urandom);
      end else begin
        // small steps, or steps right around half a turn either way
        if (sel < 7) step = int'($urandom_range(4088, 4103));
        else step = int'($urandom_range(0, 300));
        if ($urandom_range(0, 1)) step = -step;
        cnt = CNT_W'(int'(gen_count) + step);
      end
      drive_frame(cnt, next_speed(), int'($urandom), TEMP_W'($urandom));
    end
  endtask

  initial begin
    logic [DPC_W-1:0] scales [7];
    int unsigned      p;
    checker_h = new();
    quiet     = 1'b0;
    hold_rx   = 1'b0;
    gen_count = '0;
    gen_dir   = 1;
    cycles    = 0;
    settings  = 0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: first frame from count zero, field extremes, wrap edges,
    // run counter sign changes and standstill, at the reset scale
    drive_frame(13'd0, 0, 0, 8'd0);
    drive_frame(13'd100, 32767, 32767, 8'd255);
    drive_frame(13'd8191, -32768, -32768, 8'd0);     // backward across the wrap
    drive_frame(13'd10, 1, 16384, 8'h55);            // forward across the wrap
    drive_frame(13'd4105, -1, -16384, 8'haa);        // exactly +4095
    drive_frame(13'd10, -1, 16'h5555, 8'h0f);        // exactly -4095
    drive_frame(13'd4106, 0, 16'haaaa, 8'hf0);       // +4096 unwraps backward
    drive_frame(13'd10, 0, -1, 8'd1);                // -4096 unwraps forward
    drive_frame(13'd10, 5, 1, 8'd128);               // no movement
    drive_frame(13'h1555, 200, 3, 8'd7);
    drive_frame(13'h0aaa, 32767, -3, 8'd9);
    drive_frame(13'h1fff, -5, 100, 8'd11);
    drive_frame(13'h1ffe, -32768, -100, 8'd13);
    drive_frame(13'd0, 7, 12345, 8'd200);
    drive_frame(13'd1, 0, -12345, 8'd254);
    drive_frame(13'd2, -9, 0, 8'd2);
    drain();

    // scale settings: extremes, zero scale, mid value, random, back to reset
    scales[0] = 32'd1;
    scales[1] = 32'hffff_ffff;
    scales[2] = 32'd0;
    scales[3] = 32'h8000_0000;
    scales[4] = $urandom;
    scales[5] = $urandom_range(1, 32'h00ff_ffff);
    scales[6] = DPC_RESET;
    for (p = 0; p < 7; p++) begin
      write_scale(scales[p]);
      if (p == 0) begin
        // output held off while input keeps offering words
        hold_rx = 1'b1;
        run_random(40);
        run_random(PHASE_FRAMES - 40);
      end else if (p == 2) begin
        // input pauses mid phase until all results are back
        run_random(PHASE_FRAMES / 2);
        drain();
        run_random(PHASE_FRAMES / 2);
      end else begin
        run_random(PHASE_FRAMES);
      end
      drain();
    end

    $display("%0d frames decoded, %0d result words checked, %0d scale writes",
             checker_h.frames, checker_h.results, settings);
    $display("covered wrap edges, zero and full scale with delta saturation, stalls, drains");
    if (checker_h.errors == 0) begin
      $display("tb_motor_feedback_frame_decoder: done, clean");
    end else begin
      $display("tb_motor_feedback_frame_decoder: done, errors");
    end
    $finish;
  end

endmodule
